@@ design/rab_pkg.sv @@
package rab_pkg;

  // Dividend is |bound - origin| (33 bits) shifted left by 16.
  localparam int unsigned NumBits = 33;
  localparam int unsigned DenBits = 32;
  localparam int unsigned DivBits = NumBits + 16;
  localparam int unsigned QuoBits = DivBits + 1;
  localparam int unsigned ThrBits = 17;

  localparam logic signed [QuoBits-1:0] TLimit = QuoBits'(64'sh7FFF_FFFF);

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
  } rab_in_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        t_entry;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
  } rab_out_t;

  // Per-ray data that travels beside the divider lanes.
  typedef struct packed {
    logic signed [31:0] o_x;
    logic signed [31:0] o_y;
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
    logic               par_x;
    logic               par_y;
    logic               pmiss_x;
    logic               pmiss_y;
  } rab_side_t;

  // Result of the merge stage.
  typedef struct packed {
    logic               hit;
    logic [30:0]        tmin;
    logic signed [31:0] o_x;
    logic signed [31:0] o_y;
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
  } rab_mrg_t;

endpackage

@@ design/ray_aabb_slab_test.sv @@
// 2D ray versus axis-aligned box slab test in signed Q16.16. Each ray gives one
// result: hit flag, entry parameter t_entry and the entry point, all zero on a
// miss. Four divider lanes work side by side on (min - origin) / dir and
// (max - origin) / dir for both axes, one quotient bit per stage; a merge
// stage narrows the interval, and one multiplier per axis forms the hit
// point. A new ray is taken every cycle; the whole pipeline holds only while
// a finished result waits at the output. The parallel threshold register is
// written through the cfg channel (always ready) and should change only while
// the block is idle; a value of zero acts as one.
module ray_aabb_slab_test (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rab_pkg::ThrBits-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rab_pkg::rab_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rab_pkg::rab_out_t            out_data_o
);

  localparam int unsigned N  = rab_pkg::DivBits;
  localparam int unsigned NB = rab_pkg::NumBits;
  localparam int unsigned DB = rab_pkg::DenBits;
  localparam int unsigned QB = rab_pkg::QuoBits;

  logic                         en;
  logic [rab_pkg::ThrBits-1:0]  thr_q;
  logic [rab_pkg::ThrBits-1:0]  thr;

  // Advance everything unless a result is stuck at the output.
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rab_pkg::ThrBits'(1);
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign thr = (thr_q == '0) ? rab_pkg::ThrBits'(1) : thr_q;

  // ---- prep: numerators, magnitudes, parallel checks ----
  logic [DB-1:0] magd_x, magd_y;
  logic signed [NB-1:0] n_lo_x, n_hi_x, n_lo_y, n_hi_y;
  rab_pkg::rab_side_t side_d;

  logic [NB-1:0] num_q [4];
  logic [DB-1:0] den_q [4];
  logic          neg_q [4];
  rab_pkg::rab_side_t side_q;
  logic          prep_vld_q;

  assign magd_x = in_data_i.dir_x[31] ? DB'(-in_data_i.dir_x) : DB'(in_data_i.dir_x);
  assign magd_y = in_data_i.dir_y[31] ? DB'(-in_data_i.dir_y) : DB'(in_data_i.dir_y);
  assign n_lo_x = NB'(in_data_i.box_min_x) - NB'(in_data_i.origin_x);
  assign n_hi_x = NB'(in_data_i.box_max_x) - NB'(in_data_i.origin_x);
  assign n_lo_y = NB'(in_data_i.box_min_y) - NB'(in_data_i.origin_y);
  assign n_hi_y = NB'(in_data_i.box_max_y) - NB'(in_data_i.origin_y);

  always_comb begin
    side_d.o_x     = in_data_i.origin_x;
    side_d.o_y     = in_data_i.origin_y;
    side_d.d_x     = in_data_i.dir_x;
    side_d.d_y     = in_data_i.dir_y;
    side_d.par_x   = magd_x < DB'(thr);
    side_d.par_y   = magd_y < DB'(thr);
    side_d.pmiss_x = side_d.par_x && (in_data_i.origin_x < in_data_i.box_min_x ||
                                      in_data_i.origin_x > in_data_i.box_max_x);
    side_d.pmiss_y = side_d.par_y && (in_data_i.origin_y < in_data_i.box_min_y ||
                                      in_data_i.origin_y > in_data_i.box_max_y);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q[0] <= n_lo_x[NB-1] ? NB'(-n_lo_x) : NB'(n_lo_x);
      num_q[1] <= n_hi_x[NB-1] ? NB'(-n_hi_x) : NB'(n_hi_x);
      num_q[2] <= n_lo_y[NB-1] ? NB'(-n_lo_y) : NB'(n_lo_y);
      num_q[3] <= n_hi_y[NB-1] ? NB'(-n_hi_y) : NB'(n_hi_y);
      den_q[0] <= magd_x;
      den_q[1] <= magd_x;
      den_q[2] <= magd_y;
      den_q[3] <= magd_y;
      neg_q[0] <= n_lo_x[NB-1] ^ in_data_i.dir_x[31];
      neg_q[1] <= n_hi_x[NB-1] ^ in_data_i.dir_x[31];
      neg_q[2] <= n_lo_y[NB-1] ^ in_data_i.dir_y[31];
      neg_q[3] <= n_hi_y[NB-1] ^ in_data_i.dir_y[31];
      side_q   <= side_d;
    end
  end

  // ---- divider lanes ----
  logic signed [QB-1:0] quo [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    rab_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[l]),
      .den_i (den_q[l]),
      .neg_i (neg_q[l]),
      .quo_o (quo[l])
    );
  end

  // Hold ray data and valid beside the lanes.
  rab_pkg::rab_side_t side_dly_q [N];
  logic [N-1:0]       vld_dly_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dly_q[0] <= side_q;
      for (int k = 1; k < N; k++) begin
        side_dly_q[k] <= side_dly_q[k-1];
      end
    end
  end

  // ---- merge ----
  rab_pkg::rab_mrg_t mrg;
  logic              mrg_vld_q;

  rab_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en),
    .side_i   (side_dly_q[N-1]),
    .q_lo_x_i (quo[0]),
    .q_hi_x_i (quo[1]),
    .q_lo_y_i (quo[2]),
    .q_hi_y_i (quo[3]),
    .mrg_o    (mrg)
  );

  // ---- hit point product ----
  logic [62:0]        prod_x_q, prod_y_q;
  logic               mul_hit_q;
  logic [30:0]        mul_t_q;
  logic signed [31:0] mul_ox_q, mul_oy_q;
  logic               mul_nx_q, mul_ny_q;
  logic               mul_vld_q;
  logic [DB-1:0]      mmag_x, mmag_y;

  assign mmag_x = mrg.d_x[31] ? DB'(-mrg.d_x) : DB'(mrg.d_x);
  assign mmag_y = mrg.d_y[31] ? DB'(-mrg.d_y) : DB'(mrg.d_y);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q  <= 63'(mmag_x) * 63'(mrg.tmin);
      prod_y_q  <= 63'(mmag_y) * 63'(mrg.tmin);
      mul_hit_q <= mrg.hit;
      mul_t_q   <= mrg.tmin;
      mul_ox_q  <= mrg.o_x;
      mul_oy_q  <= mrg.o_y;
      mul_nx_q  <= mrg.d_x[31];
      mul_ny_q  <= mrg.d_y[31];
    end
  end

  // ---- add origin, saturate, output register ----
  function automatic logic signed [31:0] sat_add(logic signed [31:0] o, logic [62:0] p,
                                                 logic neg);
    logic signed [48:0] s;
    logic signed [48:0] r;
    s = $signed({2'b0, p[62:16]});
    r = 49'(o) + (neg ? -s : s);
    if (r > 49'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (r < -49'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return r[31:0];
  endfunction

  rab_pkg::rab_out_t out_d, out_q;
  logic              out_vld_q;

  always_comb begin
    if (mul_hit_q) begin
      out_d.hit     = 1'b1;
      out_d.t_entry = mul_t_q;
      out_d.hit_x   = sat_add(mul_ox_q, prod_x_q, mul_nx_q);
      out_d.hit_y   = sat_add(mul_oy_q, prod_y_q, mul_ny_q);
    end else begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // Valid bits for every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
      vld_dly_q  <= '0;
      mrg_vld_q  <= 1'b0;
      mul_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      prep_vld_q <= in_valid_i;
      vld_dly_q  <= {vld_dly_q[N-2:0], prep_vld_q};
      mrg_vld_q  <= vld_dly_q[N-1];
      mul_vld_q  <= mrg_vld_q;
      out_vld_q  <= mul_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ design/rab_div_lane.sv @@
module rab_div_lane (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [rab_pkg::NumBits-1:0]            num_i,
  input  logic [rab_pkg::DenBits-1:0]            den_i,
  input  logic                                   neg_i,
  output logic signed [rab_pkg::QuoBits-1:0]     quo_o
);

  localparam int unsigned N = rab_pkg::DivBits;
  localparam int unsigned D = rab_pkg::DenBits;

  logic [D-1:0] rem_q [N];
  logic [N-1:0] nq_q  [N];
  logic [D-1:0] den_q [N];
  logic         neg_q [N];

  logic [D-1:0] rem_d [N];
  logic [N-1:0] nq_d  [N];

  // One quotient bit per stage, restoring.
  always_comb begin
    logic [D-1:0] rem_in;
    logic [N-1:0] nq_in;
    logic [D-1:0] den_in;
    logic [D:0]   rs;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_in = '0;
        nq_in  = {num_i, 16'b0};
        den_in = den_i;
      end else begin
        rem_in = rem_q[k-1];
        nq_in  = nq_q[k-1];
        den_in = den_q[k-1];
      end
      rs = {rem_in, nq_in[N-1]};
      if (rs >= {1'b0, den_in}) begin
        rem_d[k] = D'(rs - {1'b0, den_in});
        nq_d[k]  = {nq_in[N-2:0], 1'b1};
      end else begin
        rem_d[k] = rs[D-1:0];
        nq_d[k]  = {nq_in[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
      end
      for (int k = 1; k < N; k++) begin
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign quo_o = neg_q[N-1] ? -$signed({1'b0, nq_q[N-1]}) : $signed({1'b0, nq_q[N-1]});

endmodule

@@ design/rab_merge.sv @@
module rab_merge (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  rab_pkg::rab_side_t                 side_i,
  input  logic signed [rab_pkg::QuoBits-1:0] q_lo_x_i,
  input  logic signed [rab_pkg::QuoBits-1:0] q_hi_x_i,
  input  logic signed [rab_pkg::QuoBits-1:0] q_lo_y_i,
  input  logic signed [rab_pkg::QuoBits-1:0] q_hi_y_i,
  output rab_pkg::rab_mrg_t                  mrg_o
);

  localparam int unsigned W = rab_pkg::QuoBits;

  rab_pkg::rab_mrg_t mrg_d, mrg_q;

  always_comb begin
    logic signed [W-1:0] t1x, t2x, t1y, t2y;
    logic signed [W-1:0] tminx, tmaxx, tminy, tmaxy, tmin, tmax;
    t1x = (q_lo_x_i > q_hi_x_i) ? q_hi_x_i : q_lo_x_i;
    t2x = (q_lo_x_i > q_hi_x_i) ? q_lo_x_i : q_hi_x_i;
    t1y = (q_lo_y_i > q_hi_y_i) ? q_hi_y_i : q_lo_y_i;
    t2y = (q_lo_y_i > q_hi_y_i) ? q_lo_y_i : q_hi_y_i;
    // Parallel axes leave the interval open.
    tminx = (side_i.par_x || t1x < 0) ? '0 : t1x;
    tmaxx = (side_i.par_x || t2x > rab_pkg::TLimit) ? rab_pkg::TLimit : t2x;
    tminy = (side_i.par_y || t1y < 0) ? '0 : t1y;
    tmaxy = (side_i.par_y || t2y > rab_pkg::TLimit) ? rab_pkg::TLimit : t2y;
    tmin  = (tminx > tminy) ? tminx : tminy;
    tmax  = (tmaxx < tmaxy) ? tmaxx : tmaxy;
    mrg_d.hit  = !side_i.pmiss_x && !side_i.pmiss_y && (tmin <= tmax);
    mrg_d.tmin = tmin[30:0];
    mrg_d.o_x  = side_i.o_x;
    mrg_d.o_y  = side_i.o_y;
    mrg_d.d_x  = side_i.d_x;
    mrg_d.d_y  = side_i.d_y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mrg_q <= mrg_d;
    end
  end

  assign mrg_o = mrg_q;

endmodule
